// ----- sv/mpf_pkg.sv -----
// ----------------------------------------------------------------------------
// MQTT packet framer package
// Shared types, request and status codes, and the command word that the
// front part hands to the back part through the command queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpf_pkg;

  // Request codes on the input channel.
  localparam logic [1:0] REQ_CONNECT    = 2'd0;
  localparam logic [1:0] REQ_PUBLISH    = 2'd1;
  localparam logic [1:0] REQ_DISCONNECT = 2'd2;
  localparam logic [1:0] REQ_DATA       = 2'd3;

  // Status codes on the output channel.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_STRAY     = 2'd2;

  // Command kinds decided by the front part.
  localparam int unsigned KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_DATA    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STRAY   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OVER    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DISC    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CONNECT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PUBLISH = 3'd5;

  localparam int unsigned REM_W = 28;
  localparam logic [REM_W-1:0] MAX_REMAINING = 28'hFFFFFFF;

  localparam logic [15:0] KEEP_ALIVE_RESET = 16'd60;

  // Command queue geometry.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] string_length;
    logic [27:0] payload_length;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_packet;
    logic       last_of_run;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              eop;
    logic [7:0]        data;
    logic [15:0]       slen;
    logic [REM_W-1:0]  remaining;
  } cmd_t;

endpackage

`default_nettype wire

// ----- sv/mpf_front.sv -----
// ----------------------------------------------------------------------------
// MQTT packet framer front part
// Accepts request beats, tracks the open packet and classifies each request
// into a command word for the back part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpf_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire mpf_pkg::in_t  in_data,
  input  wire logic          q_full,
  output logic               q_push,
  output mpf_pkg::cmd_t      q_cmd
);

  logic        packet_open;
  logic        packet_open_next;
  logic [27:0] bytes_left;
  logic [27:0] bytes_left_next;
  logic [28:0] body_pub;
  logic [28:0] rem_pub;
  logic [16:0] rem_conn;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    body_pub = {1'b0, in_data.payload_length} + 29'(in_data.string_length);
    rem_pub  = body_pub + 29'd2;
    rem_conn = 17'(in_data.string_length) + 17'd12;

    q_cmd            = '0;
    q_cmd.data       = in_data.data_byte;
    q_cmd.slen       = in_data.string_length;
    packet_open_next = packet_open;
    bytes_left_next  = bytes_left;

    case (in_data.req_type)
      mpf_pkg::REQ_DATA: begin
        if (packet_open) begin
          q_cmd.kind       = mpf_pkg::KIND_DATA;
          q_cmd.eop        = (bytes_left == 28'd1);
          bytes_left_next  = bytes_left - 28'd1;
          packet_open_next = (bytes_left != 28'd1);
        end else begin
          q_cmd.kind = mpf_pkg::KIND_STRAY;
        end
      end
      mpf_pkg::REQ_DISCONNECT: begin
        q_cmd.kind       = mpf_pkg::KIND_DISC;
        packet_open_next = 1'b0;
        bytes_left_next  = '0;
      end
      mpf_pkg::REQ_CONNECT: begin
        q_cmd.kind       = mpf_pkg::KIND_CONNECT;
        q_cmd.remaining  = 28'(rem_conn);
        q_cmd.eop        = (in_data.string_length == 16'd0);
        packet_open_next = (in_data.string_length != 16'd0);
        bytes_left_next  = 28'(in_data.string_length);
      end
      mpf_pkg::REQ_PUBLISH: begin
        // Bit 28 set means the remaining length is above the protocol limit.
        if (rem_pub[28]) begin
          q_cmd.kind       = mpf_pkg::KIND_OVER;
          packet_open_next = 1'b0;
          bytes_left_next  = '0;
        end else begin
          q_cmd.kind       = mpf_pkg::KIND_PUBLISH;
          q_cmd.remaining  = rem_pub[27:0];
          q_cmd.eop        = (body_pub == 29'd0);
          packet_open_next = (body_pub != 29'd0);
          bytes_left_next  = body_pub[27:0];
        end
      end
      default: begin
        q_cmd.kind = mpf_pkg::KIND_STRAY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open <= 1'b0;
      bytes_left  <= '0;
    end else if (q_push) begin
      packet_open <= packet_open_next;
      bytes_left  <= bytes_left_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mpf_queue.sv -----
// ----------------------------------------------------------------------------
// MQTT packet framer command queue
// Short first-in first-out queue of command words between the front part
// and the back part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire mpf_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output mpf_pkg::cmd_t      head
);

  mpf_pkg::cmd_t               mem [mpf_pkg::QDEPTH];
  logic [mpf_pkg::QPTR_W-1:0]  wr_ptr;
  logic [mpf_pkg::QPTR_W-1:0]  rd_ptr;
  logic [mpf_pkg::QPTR_W:0]    count;
  logic                        do_push;
  logic                        do_pop;

  assign full       = (count == (mpf_pkg::QPTR_W+1)'(mpf_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/mpf_back.sv -----
// ----------------------------------------------------------------------------
// MQTT packet framer back part
// Expands the command at the head of the queue into output beats, one byte
// per cycle unless the output stalls, through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpf_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata,
  input  wire logic          head_valid,
  input  wire mpf_pkg::cmd_t head,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output mpf_pkg::out_t      out_data
);

  localparam logic [2:0] PH_HEAD    = 3'd0;
  localparam logic [2:0] PH_VARINT  = 3'd1;
  localparam logic [2:0] PH_PROTO   = 3'd2;
  localparam logic [2:0] PH_SLEN_HI = 3'd3;
  localparam logic [2:0] PH_SLEN_LO = 3'd4;
  localparam logic [2:0] PH_DISC_LO = 3'd5;

  localparam logic [3:0] PROTO_LAST = 4'd9;

  logic [2:0]          phase;
  logic [2:0]          phase_next;
  logic [3:0]          idx;
  logic [3:0]          idx_next;
  logic [27:0]         len;
  logic [27:0]         len_next;
  logic [15:0]         keep_alive;
  logic                advance;
  mpf_pkg::out_t       beat;
  logic [20:0]         rest;

  // Variable header of CONNECT: protocol name, level, flags, keep-alive.
  function automatic logic [7:0] proto_byte(input logic [3:0] i, input logic [15:0] ka);
    logic [7:0] b;
    case (i)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h04;
      4'd2:    b = 8'h4D;
      4'd3:    b = 8'h51;
      4'd4:    b = 8'h54;
      4'd5:    b = 8'h54;
      4'd6:    b = 8'h04;
      4'd7:    b = 8'h02;
      4'd8:    b = ka[15:8];
      4'd9:    b = ka[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  assign advance = !out_valid || !out_stall;

  always_comb begin
    rest       = len[27:7];
    beat       = '0;
    beat.status = mpf_pkg::ST_OK;
    pop        = 1'b0;
    phase_next = phase;
    idx_next   = idx;
    len_next   = len;

    case (phase)
      PH_HEAD: begin
        case (head.kind)
          mpf_pkg::KIND_DATA: begin
            beat.out_byte      = head.data;
            beat.end_of_packet = head.eop;
            beat.last_of_run   = 1'b1;
            pop                = 1'b1;
          end
          mpf_pkg::KIND_OVER: begin
            beat.status      = mpf_pkg::ST_TOO_LARGE;
            beat.last_of_run = 1'b1;
            pop              = 1'b1;
          end
          mpf_pkg::KIND_DISC: begin
            beat.out_byte = 8'hE0;
            phase_next    = PH_DISC_LO;
          end
          mpf_pkg::KIND_CONNECT: begin
            beat.out_byte = 8'h10;
            len_next      = head.remaining;
            phase_next    = PH_VARINT;
          end
          mpf_pkg::KIND_PUBLISH: begin
            beat.out_byte = 8'h30;
            len_next      = head.remaining;
            phase_next    = PH_VARINT;
          end
          default: begin
            beat.status      = mpf_pkg::ST_STRAY;
            beat.last_of_run = 1'b1;
            pop              = 1'b1;
          end
        endcase
      end
      PH_VARINT: begin
        // Seven bits per byte, low group first; the top bit marks more to come.
        beat.out_byte = {(rest != 21'd0), len[6:0]};
        len_next      = 28'(rest);
        if (rest == 21'd0) begin
          idx_next   = '0;
          phase_next = (head.kind == mpf_pkg::KIND_CONNECT) ? PH_PROTO : PH_SLEN_HI;
        end
      end
      PH_PROTO: begin
        beat.out_byte = proto_byte(idx, keep_alive);
        if (idx == PROTO_LAST) begin
          phase_next = PH_SLEN_HI;
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      PH_SLEN_HI: begin
        beat.out_byte = head.slen[15:8];
        phase_next    = PH_SLEN_LO;
      end
      PH_SLEN_LO: begin
        beat.out_byte      = head.slen[7:0];
        beat.end_of_packet = head.eop;
        beat.last_of_run   = 1'b1;
        pop                = 1'b1;
        phase_next         = PH_HEAD;
      end
      PH_DISC_LO: begin
        beat.out_byte      = 8'h00;
        beat.end_of_packet = 1'b1;
        beat.last_of_run   = 1'b1;
        pop                = 1'b1;
        phase_next         = PH_HEAD;
      end
      default: begin
        phase_next = PH_HEAD;
      end
    endcase

    if (!(advance && head_valid)) begin
      pop        = 1'b0;
      phase_next = phase;
      idx_next   = idx;
      len_next   = len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_alive <= mpf_pkg::KEEP_ALIVE_RESET;
    end else if (cfg_we) begin
      keep_alive <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEAD;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      idx   <= idx_next;
      if (advance) begin
        out_valid <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    len <= len_next;
    if (advance && head_valid) begin
      out_data <= beat;
    end
  end

  // A multi-byte run never loses its command in the middle.
  a_run_has_head: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_HEAD) |-> head_valid)
    else $error("back part is mid-run with an empty queue");

  // Popping a command always leaves its final beat in the output register.
  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_valid && out_data.last_of_run))
    else $error("command popped without a last beat");

  // Error beats and packet ends are always the last beat of their run.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.end_of_packet || out_data.status != mpf_pkg::ST_OK))
      |-> out_data.last_of_run)
    else $error("packet end or error beat not marked last of run");

endmodule

`default_nettype wire

// ----- sv/mqtt_packet_framer.sv -----
// A request passes through the command queue, then the back part's registered output stage.
// Data bytes pass at one beat per cycle while the output is not stalled and no header is pending;
// the back part emits headers one byte a cycle: 2 bytes for DISCONNECT, up to 16 for CONNECT.
// A four-entry command queue lets requests keep arriving while a header burst drains.
// Synchronous reset closes any open packet, empties the queue and sets keep-alive to 60.
// ----------------------------------------------------------------------------
// MQTT packet framer
// Frames CONNECT, PUBLISH (QoS 0) and DISCONNECT packets as a byte stream,
// passing data bytes through and marking the final byte of each packet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mqtt_packet_framer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire mpf_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output mpf_pkg::out_t      out_data
);

  logic          q_full;
  logic          q_push;
  mpf_pkg::cmd_t q_cmd;
  logic          q_pop;
  logic          q_head_valid;
  mpf_pkg::cmd_t q_head;

  mpf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  mpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  mpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
